// ===== hdl/iprbl_pkg.sv =====
package iprbl_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W      = 32;
   localparam int LEVEL_W     = 8;
   localparam int PREFIX_W    = 6;
   localparam int CMD_W       = 2;
   localparam int STATUS_W    = 2;

   localparam logic [CMD_W-1:0] CMD_RANGE  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CIDR   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;

   localparam logic [LEVEL_W-1:0]  THRESHOLD_RESET = 8'd127;
   localparam logic [PREFIX_W-1:0] PREFIX_MAX      = 6'd32;
   localparam logic [ADDR_W-1:0]   ALL_ONES        = 32'hffff_ffff;

   typedef struct packed {
      logic [ADDR_W-1:0]  range_start;
      logic [ADDR_W-1:0]  range_end;
      logic [LEVEL_W-1:0] range_level;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_SH_CHK,
      S_SH_EV,
      S_PLACE,
      S_MX_EV,
      S_RM_CHK,
      S_RM_EV,
      S_BS_CHK,
      S_BS_EV,
      S_WK_CHK,
      S_WK_EV,
      S_DONE
   } state_type;

endpackage

// ===== hdl/iprbl_if.sv =====
interface iprbl_req_if;
   import iprbl_pkg::*;
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [ADDR_W-1:0]   range_start;
   logic [ADDR_W-1:0]   range_end;
   logic [PREFIX_W-1:0] prefix_length;
   logic [LEVEL_W-1:0]  range_level;
   logic [ADDR_W-1:0]   query_address;
   modport source (output valid, command, range_start, range_end, prefix_length,
                   range_level, query_address, input ready);
   modport sink   (input valid, command, range_start, range_end, prefix_length,
                   range_level, query_address, output ready);
endinterface

interface iprbl_rsp_if;
   import iprbl_pkg::*;
   logic                valid;
   logic                ready;
   logic                is_blocked;
   logic [STATUS_W-1:0] status;
   logic [CNT_W-1:0]    entry_count;
   modport source (output valid, is_blocked, status, entry_count, input ready);
   modport sink   (input valid, is_blocked, status, entry_count, output ready);
endinterface

interface iprbl_csr_if;
   import iprbl_pkg::*;
   logic               valid;
   logic               ready;
   logic [LEVEL_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== hdl/iprbl_ram.sv =====
module iprbl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/ip_range_blocklist_lookup.sv =====
// channel | dir | handshake   | payload
// req     | in  | valid/ready | command, range_start, range_end, prefix_length,
//         |     |             | range_level, query_address
// rsp     | out | valid/ready | is_blocked, status, entry_count
// csr     | in  | valid/ready | data = block_threshold (always ready)
// One item at a time; entry table and running-max table are two RAMs with registered reads.
// Insert shifts larger entries up, places the new one, then rebuilds the running max
// from its slot to the end; query runs a binary search, then walks back from the found slot.
// Rejected insert or unused command goes straight to the result. Ready again with rsp valid.
// Synchronous reset empties the table (count only) and sets threshold to 127.
// A new item is taken while the previous result waits in the rsp register.
module ip_range_blocklist_lookup
   import iprbl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   iprbl_req_if.sink   req,
   iprbl_rsp_if.source rsp,
   iprbl_csr_if.sink   csr
);

   state_type state_ff, state_in;

   logic [CMD_W-1:0]   cmd_ff, cmd_in;
   logic [ADDR_W-1:0]  s_ff, s_in, e_ff, e_in, addr_ff, addr_in, mx_ff, mx_in;
   logic [LEVEL_W-1:0] lvl_ff, lvl_in, thr_ff;
   logic [CNT_W-1:0]   count_ff, count_in, pos_ff, pos_in;
   logic [CNT_W-1:0]   lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in;
   logic               blk_ff, blk_in;
   logic [STATUS_W-1:0] status_ff, status_in;

   logic                rsp_valid_ff;
   logic                rsp_blk_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [CNT_W-1:0]    rsp_count_ff;

   logic                ent_we, ent_re, mx_we, mx_re;
   logic [IDX_W-1:0]    ent_waddr, ent_raddr, mx_waddr, mx_raddr;
   entry_type           ent_wdata, ent_rdata;
   logic [ADDR_W-1:0]   mx_wdata, mx_rdata;

   logic [PREFIX_W-1:0] pl_sat;
   logic [ADDR_W-1:0]   cidr_mask;
   logic [CNT_W-1:0]    mid;
   logic [ADDR_W-1:0]   mx_next;
   logic                req_fire, load_rsp, shift_stop, walk_hit;

   assign req.ready = (state_ff == S_IDLE);
   assign req_fire  = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign load_rsp  = (state_ff == S_DONE) && (!rsp_valid_ff || rsp.ready);

   assign pl_sat    = (req.prefix_length > PREFIX_MAX) ? PREFIX_MAX : req.prefix_length;
   assign cidr_mask = ~(ALL_ONES >> pl_sat);
   assign mid       = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign mx_next   = (ent_rdata.range_end > mx_ff) ? ent_rdata.range_end : mx_ff;
   assign shift_stop = (ent_rdata.range_start < s_ff) ||
                       ((ent_rdata.range_start == s_ff) && (ent_rdata.range_end <= e_ff));
   assign walk_hit  = (ent_rdata.range_start <= addr_ff) && (addr_ff <= ent_rdata.range_end)
                      && (ent_rdata.range_level > thr_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_fire) state_in = S_DISPATCH;
         S_DISPATCH: begin
            unique case (cmd_ff)
               CMD_RANGE, CMD_CIDR: begin
                  if (s_ff > e_ff || count_ff == CNT_W'(TABLE_DEPTH)) begin
                     state_in = S_DONE;
                  end else begin
                     state_in = S_SH_CHK;
                  end
               end
               CMD_QUERY: state_in = S_BS_CHK;
               default:   state_in = S_DONE;
            endcase
         end
         S_SH_CHK:   state_in = (pos_ff == '0) ? S_PLACE : S_SH_EV;
         S_SH_EV:    state_in = shift_stop ? S_PLACE : S_SH_CHK;
         S_PLACE:    state_in = (pos_ff == '0) ? S_RM_CHK : S_MX_EV;
         S_MX_EV:    state_in = S_RM_CHK;
         S_RM_CHK:   state_in = (idx_ff == count_ff) ? S_DONE : S_RM_EV;
         S_RM_EV:    state_in = S_RM_CHK;
         S_BS_CHK:   state_in = (lo_ff < hi_ff) ? S_BS_EV : S_WK_CHK;
         S_BS_EV:    state_in = S_BS_CHK;
         S_WK_CHK:   state_in = (idx_ff == '0) ? S_DONE : S_WK_EV;
         S_WK_EV: begin
            if (walk_hit || idx_ff == '0 || mx_rdata < addr_ff) begin
               state_in = S_DONE;
            end else begin
               state_in = S_WK_CHK;
            end
         end
         S_DONE:     if (load_rsp) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      cmd_in = cmd_ff;   s_in = s_ff;     e_in = e_ff;     lvl_in = lvl_ff;
      addr_in = addr_ff; mx_in = mx_ff;   count_in = count_ff;
      pos_in = pos_ff;   lo_in = lo_ff;   hi_in = hi_ff;   idx_in = idx_ff;
      blk_in = blk_ff;   status_in = status_ff;
      ent_we = 1'b0; ent_waddr = pos_ff[IDX_W-1:0]; ent_wdata = ent_rdata;
      ent_re = 1'b0; ent_raddr = '0;
      mx_we  = 1'b0; mx_waddr = idx_ff[IDX_W-1:0]; mx_wdata = mx_next;
      mx_re  = 1'b0; mx_raddr = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in  = req.command;
               lvl_in  = req.range_level;
               addr_in = req.query_address;
               if (req.command == CMD_CIDR) begin
                  s_in = req.range_start & cidr_mask;
                  e_in = (req.range_start & cidr_mask) | ~cidr_mask;
               end else begin
                  s_in = req.range_start;
                  e_in = req.range_end;
               end
            end
         end
         S_DISPATCH: begin
            blk_in    = 1'b0;
            status_in = ST_OK;
            pos_in    = count_ff;
            lo_in     = '0;
            hi_in     = count_ff;
            if (cmd_ff == CMD_RANGE || cmd_ff == CMD_CIDR) begin
               if (s_ff > e_ff) begin
                  status_in = ST_ORDER;
               end else if (count_ff == CNT_W'(TABLE_DEPTH)) begin
                  status_in = ST_FULL;
               end
            end
         end
         S_SH_CHK: begin
            ent_re    = (pos_ff != '0);
            ent_raddr = IDX_W'(pos_ff - 1'b1);
         end
         S_SH_EV: begin
            if (!shift_stop) begin
               ent_we    = 1'b1;
               ent_wdata = ent_rdata;
               pos_in    = pos_ff - 1'b1;
            end
         end
         S_PLACE: begin
            ent_we    = 1'b1;
            ent_wdata = '{range_start: s_ff, range_end: e_ff, range_level: lvl_ff};
            count_in  = count_ff + 1'b1;
            idx_in    = pos_ff;
            mx_in     = '0;
            mx_re     = (pos_ff != '0);
            mx_raddr  = IDX_W'(pos_ff - 1'b1);
         end
         S_MX_EV:  mx_in = mx_rdata;
         S_RM_CHK: begin
            ent_re    = (idx_ff != count_ff);
            ent_raddr = idx_ff[IDX_W-1:0];
         end
         S_RM_EV: begin
            mx_we  = 1'b1;
            mx_in  = mx_next;
            idx_in = idx_ff + 1'b1;
         end
         S_BS_CHK: begin
            idx_in = lo_ff;
            if (lo_ff < hi_ff) begin
               idx_in    = mid;
               ent_re    = 1'b1;
               ent_raddr = mid[IDX_W-1:0];
            end
         end
         S_BS_EV: begin
            if (addr_ff < ent_rdata.range_start) begin
               hi_in = idx_ff;
            end else begin
               lo_in = idx_ff + 1'b1;
            end
         end
         S_WK_CHK: begin
            if (idx_ff != '0) begin
               idx_in    = idx_ff - 1'b1;
               ent_re    = 1'b1;
               ent_raddr = IDX_W'(idx_ff - 1'b1);
               // running max of the entry before; wraps harmlessly at slot 0
               mx_re     = 1'b1;
               mx_raddr  = IDX_W'(idx_ff - 2'd2);
            end
         end
         S_WK_EV:  blk_in = walk_hit;
         S_DONE:   ;
         default:  ;
      endcase
   end

   iprbl_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_entry_ram (
      .clock   (clock),
      .wr_en   (ent_we),
      .wr_addr (ent_waddr),
      .wr_data (ent_wdata),
      .rd_en   (ent_re),
      .rd_addr (ent_raddr),
      .rd_data (ent_rdata)
   );

   iprbl_ram #(.WIDTH(ADDR_W), .DEPTH(TABLE_DEPTH)) u_max_ram (
      .clock   (clock),
      .wr_en   (mx_we),
      .wr_addr (mx_waddr),
      .wr_data (mx_wdata),
      .rd_en   (mx_re),
      .rd_addr (mx_raddr),
      .rd_data (mx_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         thr_ff       <= THRESHOLD_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (csr.valid && csr.ready) begin
            thr_ff <= csr.data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff    <= cmd_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      lvl_ff    <= lvl_in;
      addr_ff   <= addr_in;
      mx_ff     <= mx_in;
      pos_ff    <= pos_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      blk_ff    <= blk_in;
      status_ff <= status_in;
      if (load_rsp) begin
         rsp_blk_ff    <= blk_ff;
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.is_blocked  = rsp_blk_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.entry_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      load_rsp && status_ff == ST_FULL |=> rsp.entry_count == CNT_W'(TABLE_DEPTH))
      else $error("full status with table not full");

   a_blk_ok: assert property (@(posedge clock) disable iff (reset)
      load_rsp && blk_ff |-> status_ff == ST_OK && cmd_ff == CMD_QUERY)
      else $error("blocked result on a non-query item");

   a_walk_index: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WK_EV |-> idx_ff < count_ff)
      else $error("walk beyond stored entries");

   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_PLACE |=> count_ff == $past(count_ff) + 1'b1)
      else $error("insert did not bump count");

endmodule

// ===== test/tb_ip_range_blocklist_lookup.sv =====
module tb_ip_range_blocklist_lookup;
   timeunit 1ns;
   timeprecision 1ps;
   import iprbl_pkg::*;

   typedef struct packed {
      logic                is_blocked;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    entry_count;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   iprbl_req_if req ();
   iprbl_rsp_if rsp ();
   iprbl_csr_if csr ();

   ip_range_blocklist_lookup u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   always #5 clock = ~clock;

   // predictor state
   logic [ADDR_W-1:0]  lo_tab [TABLE_DEPTH];
   logic [ADDR_W-1:0]  hi_tab [TABLE_DEPTH];
   logic [LEVEL_W-1:0] lvl_tab [TABLE_DEPTH];
   logic [ADDR_W-1:0]  maxhi_tab [TABLE_DEPTH];
   int                 n_ranges;
   logic [LEVEL_W-1:0] threshold;

   verdict_type verdict_q [$];
   int  errors;
   int  send_idle_pct;
   int  recv_idle_pct;
   int  stall_cycles;

   function automatic logic [STATUS_W-1:0] add_range(logic [ADDR_W-1:0] s,
                                                     logic [ADDR_W-1:0] e,
                                                     logic [LEVEL_W-1:0] lvl);
      int pos;
      logic [ADDR_W-1:0] mx;
      if (s > e) return ST_ORDER;
      if (n_ranges >= TABLE_DEPTH) return ST_FULL;
      pos = n_ranges;
      while (pos > 0) begin
         if (lo_tab[pos-1] < s || (lo_tab[pos-1] == s && hi_tab[pos-1] <= e)) break;
         lo_tab[pos]  = lo_tab[pos-1];
         hi_tab[pos]  = hi_tab[pos-1];
         lvl_tab[pos] = lvl_tab[pos-1];
         pos--;
      end
      lo_tab[pos]  = s;
      hi_tab[pos]  = e;
      lvl_tab[pos] = lvl;
      n_ranges++;
      mx = (pos > 0) ? maxhi_tab[pos-1] : '0;
      for (int i = pos; i < n_ranges; i++) begin
         if (hi_tab[i] > mx) mx = hi_tab[i];
         maxhi_tab[i] = mx;
      end
      return ST_OK;
   endfunction

   function automatic logic lookup_blocked(logic [ADDR_W-1:0] a);
      int lo;
      int hi;
      int mid;
      int idx;
      lo = 0;
      hi = n_ranges;
      while (lo < hi) begin
         mid = lo + (hi - lo) / 2;
         if (a < lo_tab[mid]) hi = mid;
         else lo = mid + 1;
      end
      idx = lo;
      while (idx > 0) begin
         idx--;
         if (lo_tab[idx] <= a && a <= hi_tab[idx] && lvl_tab[idx] > threshold)
            return 1'b1;
         if (idx == 0 || maxhi_tab[idx-1] < a) break;
      end
      return 1'b0;
   endfunction

   function automatic verdict_type predict_verdict(logic [CMD_W-1:0] cmd,
                                                   logic [ADDR_W-1:0] rs,
                                                   logic [ADDR_W-1:0] re,
                                                   logic [PREFIX_W-1:0] pl,
                                                   logic [LEVEL_W-1:0] lvl,
                                                   logic [ADDR_W-1:0] qa);
      verdict_type v;
      logic [ADDR_W-1:0] mask;
      logic [ADDR_W-1:0] base;
      int plen;
      v = '0;
      if (cmd == CMD_RANGE) begin
         v.status = add_range(rs, re, lvl);
      end else if (cmd == CMD_CIDR) begin
         plen = (pl > PREFIX_MAX) ? 32 : int'(pl);
         mask = (plen == 0) ? '0 : (ALL_ONES << (32 - plen));
         base = rs & mask;
         v.status = add_range(base, base | ~mask, lvl);
      end else if (cmd == CMD_QUERY) begin
         v.is_blocked = lookup_blocked(qa);
      end
      v.entry_count = CNT_W'(n_ranges);
      return v;
   endfunction

   task automatic send_item(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] rs,
                            logic [ADDR_W-1:0] re, logic [PREFIX_W-1:0] pl,
                            logic [LEVEL_W-1:0] lvl, logic [ADDR_W-1:0] qa);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) @(negedge clock);
      req.valid         <= 1'b1;
      req.command       <= cmd;
      req.range_start   <= rs;
      req.range_end     <= re;
      req.prefix_length <= pl;
      req.range_level   <= lvl;
      req.query_address <= qa;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      verdict_q = {verdict_q, predict_verdict(cmd, rs, re, pl, lvl, qa)};
      @(negedge clock);
      req.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (verdict_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_threshold(logic [LEVEL_W-1:0] v);
      wait_drained();
      csr.valid <= 1'b1;
      csr.data  <= v;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      threshold = v;
      @(negedge clock);
      csr.valid <= 1'b0;
   endtask

   function automatic logic [ADDR_W-1:0] rand_addr();
      case ($urandom_range(3))
         0: return '0;
         1: return ALL_ONES;
         default: return $urandom();
      endcase
   endfunction

   // response side
   always @(negedge clock) begin
      rsp.ready <= (reset == 1'b0) && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (verdict_q.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
         end else begin
            want = verdict_q.pop_front();
            if (rsp.is_blocked !== want.is_blocked) begin
               $error("is_blocked expected %0d actual %0d", want.is_blocked,
                      rsp.is_blocked);
               errors++;
            end
            if (rsp.status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp.status);
               errors++;
            end
            if (rsp.entry_count !== want.entry_count) begin
               $error("entry_count expected %0d actual %0d", want.entry_count,
                      rsp.entry_count);
               errors++;
            end
         end
      end
   end

   // watchdog on cycles without any accepted item
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles > 20000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic test_directed();
      send_item(CMD_QUERY, '0, '0, '0, '0, 32'h1234_5678);
      send_item(CMD_RANGE, 32'h0a00_0000, 32'h0aff_ffff, '0, 8'd200, '0);
      send_item(CMD_RANGE, 32'h0a00_0000, 32'h0aff_ffff, '0, 8'd10, '0);
      send_item(CMD_RANGE, 32'h0a00_0000, 32'h0a00_00ff, '0, 8'd255, '0);
      send_item(CMD_RANGE, 32'h0000_0010, 32'h0000_000f, '0, 8'd255, '0);
      send_item(CMD_RANGE, ALL_ONES, ALL_ONES, '0, 8'd128, '0);
      send_item(CMD_RANGE, '0, '0, '0, 8'd127, '0);
      send_item(CMD_CIDR, 32'hc0a8_01ff, '0, 6'd24, 8'd130, '0);
      send_item(CMD_CIDR, 32'hffff_ffff, '0, 6'd63, 8'd0, '0);
      send_item(CMD_CIDR, 32'h1234_5678, '0, 6'd33, 8'd250, '0);
      send_item(CMD_QUERY, '0, '0, '0, '0, '0);
      send_item(CMD_QUERY, '0, '0, '0, '0, ALL_ONES);
      send_item(CMD_QUERY, '0, '0, '0, '0, 32'h0a00_0080);
      send_item(CMD_QUERY, '0, '0, '0, '0, 32'h0a80_0000);
      send_item(CMD_QUERY, '0, '0, '0, '0, 32'hc0a8_0105);
      send_item(CMD_QUERY, '0, '0, '0, '0, 32'h1234_5678);
      send_item(CMD_UNUSED, ALL_ONES, ALL_ONES, 6'h3f, 8'hff, ALL_ONES);
      send_item(CMD_CIDR, 32'h5555_5555, '0, 6'd0, 8'd1, '0);
      send_item(CMD_QUERY, '0, '0, '0, '0, 32'h7777_0000);
      write_threshold(8'd0);
      send_item(CMD_QUERY, '0, '0, '0, '0, 32'h7777_0000);
      write_threshold(8'd255);
      send_item(CMD_QUERY, '0, '0, '0, '0, 32'h0a00_0001);
   endtask

   task automatic test_random(int count);
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] b;
      int k;
      for (int i = 0; i < count; i++) begin
         k = $urandom_range(99);
         a = rand_addr();
         b = rand_addr();
         if (k < 30) begin
            if (k < 25 && a > b) begin
               send_item(CMD_RANGE, b, a, PREFIX_W'($urandom()), LEVEL_W'($urandom()),
                         $urandom());
            end else begin
               send_item(CMD_RANGE, a, b, PREFIX_W'($urandom()), LEVEL_W'($urandom()),
                         $urandom());
            end
         end else if (k < 45) begin
            send_item(CMD_CIDR, a, $urandom(), PREFIX_W'($urandom_range(63)),
                      LEVEL_W'($urandom()), $urandom());
         end else if (k < 97) begin
            // bias queries toward stored range edges
            if (n_ranges > 0 && $urandom_range(1)) begin
               k = $urandom_range(n_ranges - 1);
               a = $urandom_range(1) ? lo_tab[k] : hi_tab[k];
               a = a + $urandom_range(2) - 1;
            end
            send_item(CMD_QUERY, $urandom(), $urandom(), PREFIX_W'($urandom()),
                      LEVEL_W'($urandom()), a);
         end else begin
            send_item(CMD_UNUSED, $urandom(), $urandom(), PREFIX_W'($urandom()),
                      LEVEL_W'($urandom()), $urandom());
         end
      end
   endtask

   task automatic test_full_table();
      // fill to capacity, then a range, a CIDR and a reversed-range insert
      while (n_ranges < TABLE_DEPTH) begin
         send_item(CMD_RANGE, $urandom(), ALL_ONES, '0, LEVEL_W'($urandom()), '0);
      end
      send_item(CMD_RANGE, 32'd5, 32'd6, '0, 8'd1, '0);
      send_item(CMD_CIDR, 32'd5, '0, 6'd8, 8'd1, '0);
      send_item(CMD_RANGE, 32'd6, 32'd5, '0, 8'd1, '0);
   endtask

   initial begin
      errors = 0;
      n_ranges = 0;
      threshold = THRESHOLD_RESET;
      stall_cycles = 0;
      send_idle_pct = 36;
      recv_idle_pct = 85;
      req.valid = 1'b0;
      req.command = '0;
      req.range_start = '0;
      req.range_end = '0;
      req.prefix_length = '0;
      req.range_level = '0;
      req.query_address = '0;
      rsp.ready = 1'b0;
      csr.valid = 1'b0;
      csr.data = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      write_threshold(8'd127);
      test_random(200);
      send_idle_pct = 85;
      recv_idle_pct = 36;
      write_threshold(LEVEL_W'($urandom()));
      test_random(200);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_threshold(8'd0);
      test_random(150);
      test_full_table();
      write_threshold(8'd200);
      test_random(660);
      wait_drained();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
